### src/dss_pkg.sv
// dss_pkg: shared types and fixed constants for the dual stepper step generator.
// No dependencies; imported by dss_div, dual_stepper_step_generator_top and the testbench.
`timescale 1ns / 1ps

package dss_pkg;

   // step period numerator, speed offset and period limit
   localparam int unsigned PERIOD_NUM = 5500;
   localparam int unsigned SPEED_OFS  = 9;
   localparam int unsigned PERIOD_MAX = 511;

   // widths
   localparam int NUM_W   = 13;   // 5500 fits 13 bits
   localparam int DIV_W   = 10;   // |speed| + offset, at most 520
   localparam int CNT_W   = 4;    // divider step counter
   localparam int PER_W   = 9;    // period and period counter
   localparam int SPD_W   = 10;
   localparam int DIST_W  = 32;
   localparam int HEAD_W  = 16;
   localparam int REQ_DW  = 16;
   localparam int REQ_UW  = 2;
   localparam int RSP_DW  = 120;

   // register indexes
   localparam logic REG_ENABLE   = 1'b0;
   localparam logic REG_DEADBAND = 1'b1;

   // input kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_SPEED = 1'b1;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_status_type;

endpackage

### src/dss_div.sv
// dss_div: bit-serial restoring divider, PERIOD_NUM divided by a 10-bit divisor.
// One quotient bit per cycle. Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dss_pkg::DIV_W-1:0]    divisor,
   output dss_pkg::div_status_type      status
);
   import dss_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = NUM_W'(PERIOD_NUM);
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

### src/dual_stepper_step_generator_top.sv
// Dual stepper step generator with wheel odometry. A tick beat advances both
// motors, one per cycle through the same counter logic in the ST_TICK state,
// then passes through ST_DONE into the output register. A speed update beat
// runs 5500/(|speed|+9) through a bit-serial divider that produces one quotient
// bit a cycle. Its result goes from ST_DIV, once the divider is done, through
// ST_DONE into the output register, and the divider sets the rate of the block.
// One item is worked on at a time. req_tready is high only when the sequencer
// is idle, and a finished result may still be waiting in the output register
// then. A beat taken while the block is disabled goes straight to ST_DONE and
// returns the cleared state. A speed update at or below the deadband skips the
// divider and also goes straight to ST_DONE. A result that is not taken holds
// the sequencer until the output register is free.
// Depends on dss_pkg and dss_div.
`timescale 1ns / 1ps

module dual_stepper_step_generator_top #(
   parameter int PULSE_WIDTH = 9,
   parameter int MAX_SPEED   = 400
) (
   input  logic                          clock,
   input  logic                          reset,
   // request: tdata = speed[9:0], zero pad
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dss_pkg::REQ_DW-1:0]    req_tdata,
   // request: tuser = kind[0], motor[1]
   input  logic [dss_pkg::REQ_UW-1:0]    req_tuser,
   // response: tdata = step_left[0], step_right[1], dir_left[2], dir_right[3],
   // drivers_on[4], distance_left[36:5], distance_right[68:37],
   // distance_avg[100:69], heading[116:101], zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dss_pkg::RSP_DW-1:0]    rsp_tdata,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [dss_pkg::PER_W-1:0]     csr_wdata
);
   import dss_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [PER_W-1:0]        PW       = PER_W'(PULSE_WIDTH);
   localparam logic [PER_W-1:0]        PW_MIN   = PER_W'(PULSE_WIDTH + 1);
   localparam logic signed [SPD_W-1:0] MAX_S    = SPD_W'(MAX_SPEED);
   localparam logic signed [SPD_W-1:0] MIN_S    = SPD_W'(-MAX_SPEED);
   localparam logic [NUM_W-1:0]        QUO_MAX  = NUM_W'(PERIOD_MAX);

   logic [1:0]                   state_ff, state_in;
   logic                         mot_ff, mot_in;
   logic                         enable_ff, enable_in;
   logic [PER_W-1:0]             deadband_ff, deadband_in;
   logic [1:0][PER_W-1:0]        count_ff, count_in;
   logic [1:0][PER_W-1:0]        period_ff, period_in;
   logic [1:0]                   running_ff, running_in;
   logic [1:0]                   reverse_ff, reverse_in;
   logic [1:0]                   level_ff, level_in;
   logic [1:0][DIST_W-1:0]       dist_ff, dist_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]            rsp_data_ff, rsp_data_in;

   logic                         req_fire, csr_fire;
   logic signed [SPD_W-1:0]      speed_raw, speed_clamped;
   logic [PER_W-1:0]             mag;
   logic                         div_start;
   logic [DIV_W-1:0]             divisor;
   div_status_type               div_status;
   logic [PER_W-1:0]             new_period;

   // shared per-motor counter logic
   logic [PER_W-1:0]             cnt_cur, cnt_next;
   logic                         lvl;
   logic [DIST_W:0]              dist_sum;

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign speed_raw     = signed'(req_tdata[SPD_W-1:0]);
   assign speed_clamped = (speed_raw > MAX_S) ? MAX_S :
                          (speed_raw < MIN_S) ? MIN_S : speed_raw;
   assign mag     = PER_W'(speed_clamped[SPD_W-1] ? -speed_clamped : speed_clamped);
   assign divisor = DIV_W'(mag) + DIV_W'(SPEED_OFS);
   assign div_start = req_fire && enable_ff && (req_tuser[0] == KIND_SPEED)
                      && (mag > deadband_ff);

   dss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (divisor),
      .status  (div_status)
   );

   always_comb begin
      if (div_status.quotient > QUO_MAX)
         new_period = PER_W'(PERIOD_MAX);
      else if (div_status.quotient[PER_W-1:0] <= PW)
         new_period = PW_MIN;
      else
         new_period = div_status.quotient[PER_W-1:0];
   end

   assign cnt_cur  = (count_ff[mot_ff] >= period_ff[mot_ff]) ? '0 : count_ff[mot_ff];
   assign lvl      = cnt_cur < PW;
   assign cnt_next = ((cnt_cur + 1'b1) >= period_ff[mot_ff]) ? '0 : cnt_cur + 1'b1;
   assign dist_sum = {dist_ff[0][DIST_W-1], dist_ff[0]} + {dist_ff[1][DIST_W-1], dist_ff[1]};

   always_comb begin
      state_in     = state_ff;
      mot_in       = mot_ff;
      enable_in    = enable_ff;
      deadband_in  = deadband_ff;
      count_in     = count_ff;
      period_in    = period_ff;
      running_in   = running_ff;
      reverse_in   = reverse_ff;
      level_in     = level_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_fire) begin
         case (csr_index)
            REG_ENABLE: begin
               enable_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  count_in   = '0;
                  period_in  = '0;
                  running_in = '0;
                  reverse_in = '0;
                  level_in   = '0;
                  dist_in    = '0;
               end
            end
            REG_DEADBAND: deadband_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DONE;
               if (enable_ff) begin
                  if (req_tuser[0] == KIND_TICK) begin
                     state_in = ST_TICK;
                     mot_in   = 1'b0;
                  end else begin
                     mot_in = req_tuser[1];
                     reverse_in[req_tuser[1]] = speed_clamped[SPD_W-1];
                     if (div_start) begin
                        state_in = ST_DIV;
                     end else begin
                        running_in[req_tuser[1]] = 1'b0;
                        period_in[req_tuser[1]]  = '0;
                        count_in[req_tuser[1]]   = '0;
                        level_in[req_tuser[1]]   = 1'b0;
                     end
                  end
               end
            end
         end
         ST_TICK: begin
            if (running_ff[mot_ff]) begin
               if (lvl && !level_ff[mot_ff])
                  dist_in[mot_ff] = reverse_ff[mot_ff] ? dist_ff[mot_ff] - 1'b1
                                                       : dist_ff[mot_ff] + 1'b1;
               level_in[mot_ff] = lvl;
               count_in[mot_ff] = cnt_next;
            end
            if (mot_ff)
               state_in = ST_DONE;
            mot_in = 1'b1;
         end
         ST_DIV: begin
            if (div_status.done) begin
               period_in[mot_ff]  = new_period;
               running_in[mot_ff] = 1'b1;
               state_in           = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000,
                               HEAD_W'(dist_ff[1][HEAD_W-1:0] - dist_ff[0][HEAD_W-1:0]),
                               dist_sum[DIST_W:1],
                               dist_ff[1],
                               dist_ff[0],
                               running_ff[0] | running_ff[1],
                               ~reverse_ff[1],
                               reverse_ff[0],
                               level_ff[1],
                               level_ff[0]};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mot_ff      <= mot_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         deadband_ff  <= PER_W'(6);
         count_ff     <= '0;
         period_ff    <= '0;
         running_ff   <= '0;
         reverse_ff   <= '0;
         level_ff     <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         deadband_ff  <= deadband_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         running_ff   <= running_in;
         reverse_ff   <= reverse_in;
         level_ff     <= level_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a running motor always has a period with at least one low tick
   a_period_min: assert property (@(posedge clock) disable iff (reset)
      (!running_ff[0] || period_ff[0] > PW) && (!running_ff[1] || period_ff[1] > PW))
      else $error("running motor with short period");

   // a stopped motor holds a cleared counter and a low step level
   a_stopped: assert property (@(posedge clock) disable iff (reset)
      (running_ff[0] || (count_ff[0] == '0 && level_ff[0] == 1'b0)) &&
      (running_ff[1] || (count_ff[1] == '0 && level_ff[1] == 1'b0)))
      else $error("stopped motor not cleared");

   // disabled block keeps odometry and motors cleared
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      !enable_ff |-> (dist_ff == '0 && running_ff == 2'b00))
      else $error("state changed while disabled");

   // divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider result outside divide phase");

   // an accepted beat always leaves the idle state
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("sequencer stayed idle after a beat");
`endif

endmodule

### tb/sv/dual_stepper_step_generator_top_tb.sv
// Self-checking bench for dual_stepper_step_generator_top: speed and tick beats go in,
// and every status beat is checked against an in-bench odometry predictor.
// Depends on dss_pkg and the dual_stepper_step_generator_top RTL.
`timescale 1ns / 1ps

module dual_stepper_step_generator_top_tb;
   import dss_pkg::*;

   localparam int STEP_PULSE   = 9;
   localparam int TOP_SPEED    = 400;
   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 40;

   // status fields, step_left in the lowest bit as on rsp_tdata
   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic [DIST_W-1:0] distance_avg;
      logic [DIST_W-1:0] distance_right;
      logic [DIST_W-1:0] distance_left;
      logic              drivers_on;
      logic              dir_right;
      logic              dir_left;
      logic              step_right;
      logic              step_left;
   } odometry_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic [REQ_UW-1:0]   req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = REG_ENABLE;
   logic [PER_W-1:0]    csr_wdata = '0;

   // predictor copy of the block state
   logic                enable_r;
   logic [PER_W-1:0]    deadband_r;
   logic [PER_W-1:0]    wheel_count [2];
   logic [PER_W-1:0]    wheel_period [2];
   logic                wheel_run [2];
   logic                wheel_rev [2];
   logic                wheel_level [2];
   logic [DIST_W-1:0]   wheel_dist [2];

   odometry_type        odometry_q [$];
   odometry_type        wanted_beat;
   odometry_type        seen_beat;
   int unsigned         mismatches = 0;
   int unsigned         cycles = 0;
   int unsigned         burst_left = 0;
   int unsigned         gap_len = 0;
   logic [15:0]         ready_pattern = 16'hFFFF;
   int unsigned         pattern_age = 0;

   dual_stepper_step_generator_top #(
      .PULSE_WIDTH(STEP_PULSE),
      .MAX_SPEED  (TOP_SPEED)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic void clear_wheels();
      for (int m = 0; m < 2; m++) begin
         wheel_count[m]  = '0;
         wheel_period[m] = '0;
         wheel_run[m]    = 1'b0;
         wheel_rev[m]    = 1'b0;
         wheel_level[m]  = 1'b0;
         wheel_dist[m]   = '0;
      end
   endfunction

   function automatic void set_wheel_speed(int m, logic [SPD_W-1:0] raw);
      int          s;
      int unsigned mag;
      int unsigned p;
      s = $signed(raw);
      if (s > TOP_SPEED) s = TOP_SPEED;
      if (s < -TOP_SPEED) s = -TOP_SPEED;
      wheel_rev[m] = (s < 0);
      mag = (s < 0) ? -s : s;
      if (mag > deadband_r) begin
         p = PERIOD_NUM / (mag + SPEED_OFS);
         if (p > PERIOD_MAX) p = PERIOD_MAX;
         if (p <= STEP_PULSE) p = STEP_PULSE + 1;
         wheel_period[m] = p[PER_W-1:0];
         wheel_run[m]    = 1'b1;
      end else begin
         wheel_run[m]    = 1'b0;
         wheel_period[m] = '0;
         wheel_count[m]  = '0;
         wheel_level[m]  = 1'b0;
      end
   endfunction

   function automatic void advance_wheel(int m);
      logic lvl;
      if (!wheel_run[m]) return;
      if (wheel_count[m] >= wheel_period[m]) wheel_count[m] = '0;
      lvl = (wheel_count[m] < STEP_PULSE);
      // one count per rising step edge
      if (lvl && !wheel_level[m])
         wheel_dist[m] += wheel_rev[m] ? 32'hFFFF_FFFF : 32'd1;
      wheel_level[m] = lvl;
      wheel_count[m] += 1'b1;
      if (wheel_count[m] >= wheel_period[m]) wheel_count[m] = '0;
   endfunction

   function automatic odometry_type odometry_snapshot();
      odometry_type      r;
      logic [DIST_W:0]   sum;
      logic [DIST_W-1:0] diff;
      sum  = {wheel_dist[0][DIST_W-1], wheel_dist[0]} + {wheel_dist[1][DIST_W-1], wheel_dist[1]};
      diff = wheel_dist[1] - wheel_dist[0];
      r.step_left      = wheel_level[0];
      r.step_right     = wheel_level[1];
      r.dir_left       = wheel_rev[0];
      r.dir_right      = ~wheel_rev[1];
      r.drivers_on     = wheel_run[0] | wheel_run[1];
      r.distance_left  = wheel_dist[0];
      r.distance_right = wheel_dist[1];
      r.distance_avg   = sum[DIST_W:1];
      r.heading        = diff[HEAD_W-1:0];
      return r;
   endfunction

   function automatic odometry_type step_odometry(logic kind, logic motor,
                                                  logic [SPD_W-1:0] speed);
      if (enable_r) begin
         if (kind == KIND_TICK) begin
            advance_wheel(0);
            advance_wheel(1);
         end else begin
            set_wheel_speed(motor, speed);
         end
      end
      return odometry_snapshot();
   endfunction

   // ---------------- result checking ----------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (odometry_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status beat with nothing expected, tdata %h", rsp_tdata);
         end else begin
            wanted_beat = odometry_q.pop_front();
            seen_beat   = odometry_type'(rsp_tdata[$bits(odometry_type)-1:0]);
            check_field("step_left", wanted_beat.step_left, seen_beat.step_left);
            check_field("step_right", wanted_beat.step_right, seen_beat.step_right);
            check_field("dir_left", wanted_beat.dir_left, seen_beat.dir_left);
            check_field("dir_right", wanted_beat.dir_right, seen_beat.dir_right);
            check_field("drivers_on", wanted_beat.drivers_on, seen_beat.drivers_on);
            check_field("distance_left", wanted_beat.distance_left, seen_beat.distance_left);
            check_field("distance_right", wanted_beat.distance_right,
                        seen_beat.distance_right);
            check_field("distance_avg", wanted_beat.distance_avg, seen_beat.distance_avg);
            check_field("heading", wanted_beat.heading, seen_beat.heading);
         end
      end
   end

   // receiver backpressure: a rotating 16-bit pattern, replaced whenever pattern_age wraps
   always @(posedge clock) begin
      if (pattern_age == 47) begin
         pattern_age   = 0;
         ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
         pattern_age++;
      end
      rsp_tready    <= ready_pattern[0];
      ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
   end

   // ---------------- stimulus helpers ----------------

   // leaves tvalid high when the burst goes on, so back-to-back beats see no bubble
   task automatic send_beat(logic kind, logic motor, logic [SPD_W-1:0] speed);
      req_tvalid <= 1'b1;
      req_tuser  <= {motor, kind};
      req_tdata  <= {{(REQ_DW-SPD_W){1'b0}}, speed};
      do @(posedge clock); while (!req_tready);
      odometry_q.push_back(step_odometry(kind, motor, speed));
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
   endtask

   // always waits for a clock edge, so tvalid is never lowered and raised in one step
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (odometry_q.size() != 0);
   endtask

   task automatic write_reg(logic idx, logic [PER_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_ENABLE) begin
         enable_r = val[0];
         if (!enable_r) clear_wheels();
      end else begin
         deadband_r = val;
      end
   endtask

   function automatic logic [SPD_W-1:0] pick_speed(int db);
      int v;
      case ($urandom_range(0, 4))
         0:       v = int'($urandom_range(0, 1023)) - 512;
         1:       v = db + int'($urandom_range(0, 2)) - 1;   // straddle the deadband
         2:       v = $urandom_range(390, 512);              // clamp region
         default: v = $urandom_range(1, TOP_SPEED);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      if (v > 511) v = 511;
      if (v < -512) v = -512;
      return v[SPD_W-1:0];
   endfunction

   task automatic run_traffic(int unsigned beats, int unsigned speed_pct);
      for (int unsigned i = 0; i < beats; i++) begin
         if (i == beats / 2) wait_drained();
         if ($urandom_range(0, 99) < speed_pct)
            send_beat(KIND_SPEED, 1'($urandom_range(0, 1)), pick_speed(deadband_r));
         else
            send_beat(KIND_TICK, 1'($urandom_range(0, 1)), 10'($urandom));
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_disabled_block();
      send_beat(KIND_TICK, 1'b1, 10'h3FF);
      send_beat(KIND_SPEED, 1'b0, 10'd300);
   endtask

   task automatic test_clamp_and_restart();
      write_reg(REG_DEADBAND, 9'd6);
      write_reg(REG_ENABLE, 9'd1);
      send_beat(KIND_SPEED, 1'b0, 10'd7);          // left just above the deadband
      send_beat(KIND_SPEED, 1'b1, 10'h200);        // right full reverse, clamped
      repeat (13) send_beat(KIND_TICK, 1'b0, 10'd0);
      // left counter now past the new short period, restarts on next tick
      send_beat(KIND_SPEED, 1'b0, 10'd511);
      repeat (2) send_beat(KIND_TICK, 1'b0, 10'd0);
      send_beat(KIND_SPEED, 1'b0, 10'd6);          // at the deadband: stop
      send_beat(KIND_SPEED, 1'b1, -10'sd7);
      send_beat(KIND_TICK, 1'b1, 10'd0);
   endtask

   task automatic test_deadband_limits();
      write_reg(REG_DEADBAND, 9'd0);
      send_beat(KIND_SPEED, 1'b0, 10'd1);          // period saturates
      send_beat(KIND_TICK, 1'b0, 10'd0);
      write_reg(REG_DEADBAND, 9'd400);
      send_beat(KIND_SPEED, 1'b1, 10'd400);
      send_beat(KIND_SPEED, 1'b0, -10'sd400);
      send_beat(KIND_TICK, 1'b0, 10'd0);
   endtask

   task automatic test_default_deadband();
      write_reg(REG_DEADBAND, 9'd6);
      run_traffic(450, 12);
   endtask

   task automatic test_slow_periods();
      write_reg(REG_DEADBAND, 9'd0);
      run_traffic(250, 8);
   endtask

   task automatic test_excess_deadband();
      write_reg(REG_DEADBAND, 9'd400);
      run_traffic(80, 30);
   endtask

   task automatic test_enable_toggle();
      write_reg(REG_ENABLE, 9'd0);
      run_traffic(40, 40);
      write_reg(REG_DEADBAND, 9'($urandom_range(0, 60)));
      write_reg(REG_ENABLE, 9'd1);
      run_traffic(300, 12);
   endtask

   task automatic test_random_deadbands();
      for (int k = 0; k < 4; k++) begin
         write_reg(REG_DEADBAND, 9'($urandom_range(0, 400)));
         run_traffic(80, 15);
      end
   endtask

   initial begin
      enable_r   = 1'b0;
      deadband_r = 9'd6;
      clear_wheels();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_block();
      test_clamp_and_restart();
      test_deadband_limits();
      test_default_deadband();
      test_slow_periods();
      test_excess_deadband();
      test_enable_toggle();
      test_random_deadbands();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && odometry_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
